/* rtl/positional_list_engine_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the positional list engine
// Shared wrappers that clock every check on clk and mute it during reset.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_CORE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/ple_pkg.sv */
// ----------------------------------------------------------------------------
// ple_pkg
// Widths, request and status codes, and the microprogram of the list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int DATA_W    = 32;
	localparam int REQ_W     = 3;
	localparam int POS_W     = 5;
	localparam int STAT_W    = 2;
	localparam int CNT_OUT_W = 5;
	localparam int DEPTH_DEF = 16;

	localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_INS_POS   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_INS_BACK  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_DEL_FRONT = 3'd3;
	localparam logic [REQ_W-1:0] REQ_DEL_POS   = 3'd4;
	localparam logic [REQ_W-1:0] REQ_DEL_BACK  = 3'd5;

	localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

	// Datapath operation selected by one control word.
	typedef enum logic [3:0] {
		OP_NONE    = 4'd0,
		OP_TAKE    = 4'd1,
		OP_CHECK   = 4'd2,
		OP_UP_RD   = 4'd3,
		OP_UP_WR   = 4'd4,
		OP_PUT     = 4'd5,
		OP_DN_RD   = 4'd6,
		OP_DN_WR   = 4'd7,
		OP_TAIL_RD = 4'd8,
		OP_DROP    = 4'd9,
		OP_FIN     = 4'd10
	} uop_t;

	// Branch condition tested by one control word.
	typedef enum logic [2:0] {
		C_ALWAYS   = 3'd0,
		C_NO_REQ   = 3'd1,
		C_SKIP     = 3'd2,
		C_DEL      = 3'd3,
		C_UP_DONE  = 3'd4,
		C_DN_DONE  = 3'd5,
		C_OUT_BUSY = 3'd6
	} cond_t;

	typedef logic [3:0] upc_t;

	typedef struct packed {
		uop_t  op;
		cond_t cond;
		upc_t  jt;
		upc_t  jf;
	} ctl_t;

	localparam upc_t U_IDLE  = 4'd0;
	localparam upc_t U_CHECK = 4'd1;
	localparam upc_t U_SKIPT = 4'd2;
	localparam upc_t U_KIND  = 4'd3;
	localparam upc_t U_ILOOP = 4'd4;
	localparam upc_t U_IMOVE = 4'd5;
	localparam upc_t U_IPUT  = 4'd6;
	localparam upc_t U_DLOOP = 4'd7;
	localparam upc_t U_DMOVE = 4'd8;
	localparam upc_t U_DTAIL = 4'd9;
	localparam upc_t U_DDROP = 4'd10;
	localparam upc_t U_FIN   = 4'd11;

	// Control store: the jump goes to jt when the condition holds, else to jf.
	function automatic ctl_t ucode(input upc_t a);
		ctl_t w;
		begin
			case (a)
				U_IDLE:  w = '{op: OP_TAKE,    cond: C_NO_REQ,   jt: U_IDLE,  jf: U_CHECK};
				U_CHECK: w = '{op: OP_CHECK,   cond: C_ALWAYS,   jt: U_SKIPT, jf: U_SKIPT};
				U_SKIPT: w = '{op: OP_NONE,    cond: C_SKIP,     jt: U_FIN,   jf: U_KIND};
				U_KIND:  w = '{op: OP_NONE,    cond: C_DEL,      jt: U_DLOOP, jf: U_ILOOP};
				U_ILOOP: w = '{op: OP_UP_RD,   cond: C_UP_DONE,  jt: U_IPUT,  jf: U_IMOVE};
				U_IMOVE: w = '{op: OP_UP_WR,   cond: C_ALWAYS,   jt: U_ILOOP, jf: U_ILOOP};
				U_IPUT:  w = '{op: OP_PUT,     cond: C_ALWAYS,   jt: U_FIN,   jf: U_FIN};
				U_DLOOP: w = '{op: OP_DN_RD,   cond: C_DN_DONE,  jt: U_DTAIL, jf: U_DMOVE};
				U_DMOVE: w = '{op: OP_DN_WR,   cond: C_ALWAYS,   jt: U_DLOOP, jf: U_DLOOP};
				U_DTAIL: w = '{op: OP_TAIL_RD, cond: C_ALWAYS,   jt: U_DDROP, jf: U_DDROP};
				U_DDROP: w = '{op: OP_DROP,    cond: C_ALWAYS,   jt: U_FIN,   jf: U_FIN};
				U_FIN:   w = '{op: OP_FIN,     cond: C_OUT_BUSY, jt: U_FIN,   jf: U_IDLE};
				default: w = '{op: OP_NONE,    cond: C_ALWAYS,   jt: U_IDLE,  jf: U_IDLE};
			endcase
			return w;
		end
	endfunction

endpackage

/* rtl/ple_ram.sv */
// ----------------------------------------------------------------------------
// ple_ram
// Generic RAM with one write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ple_ram #(
	parameter int W = ple_pkg::DATA_W,
	parameter int D = ple_pkg::DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/positional_list_engine_core.sv */
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Bounded ordered list of signed 32-bit entries with front, back and
// positional insert and delete, driven by a small microprogram.
// ----------------------------------------------------------------------------
// The engine keeps up to DEPTH entries in order in a RAM, front first, with a
// live count beside it, and answers every request transaction with exactly one
// result transaction carrying a status, the new count and the new front and
// back values (zero when the list is empty). One request is worked on at a
// time. A refused request or an unknown request type moves no entries; an
// insert or a delete moves up to DEPTH - 1 entries one place to open or close
// the gap, one entry at a time through the single RAM, with a registered read
// and then a write for each. The result waits in an output register, so the
// next request can be worked on while it is still unclaimed.
module positional_list_engine_core #(
	parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  logic        [ple_pkg::REQ_W-1:0]     req_type,
	input  logic signed [ple_pkg::DATA_W-1:0]    value,
	input  logic        [ple_pkg::POS_W-1:0]     position,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output logic        [ple_pkg::STAT_W-1:0]    status,
	output logic        [ple_pkg::CNT_OUT_W-1:0] entry_count,
	output logic signed [ple_pkg::DATA_W-1:0]    front_value,
	output logic signed [ple_pkg::DATA_W-1:0]    back_value
);

	`include "positional_list_engine_core_defines.svh"

	// Address width of the store, width of a count that can reach DEPTH, and a
	// width wide enough to compare a position with the count plus one.
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;

	// Sequencer.
	ple_pkg::upc_t upc_q;
	ple_pkg::upc_t upc_d;
	ple_pkg::ctl_t ctl;
	logic          cond_hit;

	// Request held for the duration of the program.
	logic [ple_pkg::REQ_W-1:0]  req_q;
	logic [ple_pkg::DATA_W-1:0] val_q;
	logic [ple_pkg::POS_W-1:0]  pos_q;

	// Datapath registers.
	logic [CW-1:0]               cnt_q;
	logic [CW-1:0]               ptr_q;
	logic [CW-1:0]               tgt_q;
	logic [ple_pkg::STAT_W-1:0]  stat_q;
	logic                        del_q;
	logic                        skip_q;
	logic [ple_pkg::DATA_W-1:0]  front_q;
	logic [ple_pkg::DATA_W-1:0]  back_q;

	// Output register.
	logic                          rsp_valid_q;
	logic [ple_pkg::STAT_W-1:0]    rsp_stat_q;
	logic [ple_pkg::CNT_OUT_W-1:0] rsp_cnt_q;
	logic [ple_pkg::DATA_W-1:0]    rsp_front_q;
	logic [ple_pkg::DATA_W-1:0]    rsp_back_q;
	logic                          out_busy;

	// Request check.
	logic [XW-1:0]              cnt_x;
	logic [XW-1:0]              pos_x;
	logic [XW-1:0]              chk_tgt_x;
	logic [ple_pkg::STAT_W-1:0] chk_stat;
	logic                       chk_del;
	logic                       chk_nop;
	logic                       is_full;
	logic                       is_empty;

	// Address arithmetic.
	logic [CW-1:0] ptr_dec;
	logic [CW-1:0] ptr_inc;
	logic [CW-1:0] cnt_dec1;
	logic [CW-1:0] cnt_dec2;

	// Store port.
	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [ple_pkg::DATA_W-1:0] ram_wdata;
	logic [AW-1:0]              ram_raddr;
	logic [ple_pkg::DATA_W-1:0] ram_rdata;

	assign ctl       = ple_pkg::ucode(upc_q);
	assign req_ready = (ctl.op == ple_pkg::OP_TAKE);
	assign out_busy  = rsp_valid_q && !rsp_ready;

	assign ptr_dec  = ptr_q - CW'(1);
	assign ptr_inc  = ptr_q + CW'(1);
	assign cnt_dec1 = cnt_q - CW'(1);
	assign cnt_dec2 = cnt_q - CW'(2);

	// The jump condition of the current control word picks the next step.
	always_comb begin
		unique case (ctl.cond)
			ple_pkg::C_ALWAYS:   cond_hit = 1'b1;
			ple_pkg::C_NO_REQ:   cond_hit = !req_valid;
			ple_pkg::C_SKIP:     cond_hit = skip_q;
			ple_pkg::C_DEL:      cond_hit = del_q;
			ple_pkg::C_UP_DONE:  cond_hit = (ptr_q <= tgt_q);
			ple_pkg::C_DN_DONE:  cond_hit = (ptr_inc >= cnt_q);
			ple_pkg::C_OUT_BUSY: cond_hit = out_busy;
			default:             cond_hit = 1'b1;
		endcase
		upc_d = cond_hit ? ctl.jt : ctl.jf;
	end

	// Decode the held request against the current count. A positional insert
	// checks its position before it checks for a full store; any delete on an
	// empty list reports empty whatever its position.
	assign cnt_x    = XW'(cnt_q);
	assign pos_x    = XW'(pos_q);
	assign is_full  = (cnt_q >= CW'(DEPTH));
	assign is_empty = (cnt_q == '0);

	always_comb begin
		chk_stat  = ple_pkg::ST_DONE;
		chk_tgt_x = '0;
		chk_del   = 1'b0;
		chk_nop   = 1'b0;
		unique case (req_q)
			ple_pkg::REQ_INS_FRONT: begin
				if (is_full) begin
					chk_stat = ple_pkg::ST_FULL;
				end
			end
			ple_pkg::REQ_INS_POS: begin
				chk_tgt_x = pos_x - XW'(1);
				if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
					chk_stat = ple_pkg::ST_BADPOS;
				end else if (is_full) begin
					chk_stat = ple_pkg::ST_FULL;
				end
			end
			ple_pkg::REQ_INS_BACK: begin
				chk_tgt_x = cnt_x;
				if (is_full) begin
					chk_stat = ple_pkg::ST_FULL;
				end
			end
			ple_pkg::REQ_DEL_FRONT: begin
				chk_del = 1'b1;
				if (is_empty) begin
					chk_stat = ple_pkg::ST_EMPTY;
				end
			end
			ple_pkg::REQ_DEL_POS: begin
				chk_del   = 1'b1;
				chk_tgt_x = pos_x - XW'(1);
				if (is_empty) begin
					chk_stat = ple_pkg::ST_EMPTY;
				end else if (pos_x == '0 || pos_x > cnt_x) begin
					chk_stat = ple_pkg::ST_BADPOS;
				end
			end
			ple_pkg::REQ_DEL_BACK: begin
				chk_del   = 1'b1;
				chk_tgt_x = cnt_x - XW'(1);
				if (is_empty) begin
					chk_stat = ple_pkg::ST_EMPTY;
				end
			end
			default: begin
				chk_nop = 1'b1;
			end
		endcase
	end

	// Store addressing. An insert walks the pointer down from the count,
	// copying each entry one place up; a delete walks it up from the target,
	// copying each entry one place down. Each write uses the data read in the step before it.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q[AW-1:0];
		ram_wdata = ram_rdata;
		ram_raddr = ptr_dec[AW-1:0];
		case (ctl.op)
			ple_pkg::OP_UP_RD: begin
				ram_raddr = ptr_dec[AW-1:0];
			end
			ple_pkg::OP_UP_WR, ple_pkg::OP_DN_WR: begin
				ram_we = 1'b1;
			end
			ple_pkg::OP_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = tgt_q[AW-1:0];
				ram_wdata = val_q;
			end
			ple_pkg::OP_DN_RD: begin
				ram_raddr = ptr_inc[AW-1:0];
			end
			ple_pkg::OP_TAIL_RD: begin
				ram_raddr = cnt_dec2[AW-1:0];
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	ple_ram #(
		.W(ple_pkg::DATA_W),
		.D(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Control state: step counter, live count and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= ple_pkg::U_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			upc_q <= upc_d;
			if (ctl.op == ple_pkg::OP_PUT) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (ctl.op == ple_pkg::OP_DROP) begin
				cnt_q <= cnt_dec1;
			end
			if (ctl.op == ple_pkg::OP_FIN && !out_busy) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers. The front and back values are tracked beside the
	// store so that a result never needs a read of its own, except when a
	// delete removes the last entry and the one before it becomes the back.
	always_ff @(posedge clk) begin
		case (ctl.op)
			ple_pkg::OP_TAKE: begin
				if (req_valid) begin
					req_q <= req_type;
					val_q <= value;
					pos_q <= position;
				end
			end
			ple_pkg::OP_CHECK: begin
				stat_q <= chk_stat;
				tgt_q  <= chk_tgt_x[CW-1:0];
				del_q  <= chk_del;
				skip_q <= chk_nop || (chk_stat != ple_pkg::ST_DONE);
				ptr_q  <= chk_del ? chk_tgt_x[CW-1:0] : cnt_q;
			end
			ple_pkg::OP_UP_WR: begin
				ptr_q <= ptr_dec;
			end
			ple_pkg::OP_PUT: begin
				if (tgt_q == '0) begin
					front_q <= val_q;
				end
				if (tgt_q == cnt_q) begin
					back_q <= val_q;
				end
			end
			ple_pkg::OP_DN_WR: begin
				if (ptr_q == '0) begin
					front_q <= ram_rdata;
				end
				ptr_q <= ptr_inc;
			end
			ple_pkg::OP_DROP: begin
				if (tgt_q == cnt_dec1) begin
					back_q <= ram_rdata;
				end
			end
			ple_pkg::OP_FIN: begin
				if (!out_busy) begin
					rsp_stat_q  <= stat_q;
					rsp_cnt_q   <= cnt_x[ple_pkg::CNT_OUT_W-1:0];
					rsp_front_q <= is_empty ? '0 : front_q;
					rsp_back_q  <= is_empty ? '0 : back_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = rsp_stat_q;
	assign entry_count = rsp_cnt_q;
	assign front_value = rsp_front_q;
	assign back_value  = rsp_back_q;

	// An accepted request always starts the program at the check step.
	`PLE_ASSERT_NEXT(a_take_to_check, req_valid && req_ready, upc_q == ple_pkg::U_CHECK, "accepted request did not reach the check step")

	// The count moves only on the steps that commit an insert or a delete.
	`PLE_ASSERT_NEXT(a_count_steady, ctl.op != ple_pkg::OP_PUT && ctl.op != ple_pkg::OP_DROP, $stable(cnt_q), "count changed outside a commit step")

	// An upward copy never reaches below the insert target.
	`PLE_ASSERT_NOW(a_up_in_range, ctl.op == ple_pkg::OP_UP_WR, ptr_q > tgt_q && ptr_q < CW'(DEPTH), "upward copy outside the open gap")

	// A downward copy never reads past the last live entry.
	`PLE_ASSERT_NOW(a_dn_in_range, ctl.op == ple_pkg::OP_DN_WR, ptr_inc < cnt_q, "downward copy past the last entry")

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for positional_list_engine_core
// This testbench runs a short table of directed requests through the list
// engine, then three phases of random requests with different idling on the
// request and response sides. Every accepted result is checked, field by
// field, against its table row or the software list's prediction.
// ----------------------------------------------------------------------------
module testbench;
	import ple_pkg::*;

	localparam int LIST_DEPTH  = DEPTH_DEF;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 60;
	localparam int MAX_REPORTS = 10;

	// Request types 6 and 7 are not defined and leave the list untouched.
	localparam logic [REQ_W-1:0] REQ_NOP_A = 3'd6;
	localparam logic [REQ_W-1:0] REQ_NOP_B = 3'd7;

	localparam logic [DATA_W-1:0] VAL_MIN  = 32'h8000_0000;
	localparam logic [DATA_W-1:0] VAL_MAX  = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] VAL_NEG1 = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [STAT_W-1:0]    st;
		logic [CNT_OUT_W-1:0] cnt;
		logic [DATA_W-1:0]    front;
		logic [DATA_W-1:0]    back;
	} list_result_t;

	typedef struct {
		logic [REQ_W-1:0]  rt;
		logic [DATA_W-1:0] val;
		logic [POS_W-1:0]  pos;
		int                reps;
		bit                typed;
		list_result_t      want;
	} stim_row_t;

	logic                        clk;
	logic                        arst_n;
	logic                        req_valid;
	logic                        req_ready;
	logic        [REQ_W-1:0]     req_type;
	logic signed [DATA_W-1:0]    value;
	logic        [POS_W-1:0]     position;
	logic                        rsp_valid;
	logic                        rsp_ready;
	logic        [STAT_W-1:0]    status;
	logic        [CNT_OUT_W-1:0] entry_count;
	logic signed [DATA_W-1:0]    front_value;
	logic signed [DATA_W-1:0]    back_value;

	// Software copy of the list, front first.
	logic [DATA_W-1:0] list_mem [LIST_DEPTH];
	int                list_len;

	list_result_t expected_results [$];
	stim_row_t    stim_rows [$];

	int error_count;
	int sent_count;
	int checked_count;
	int stall_cycles;
	int send_idle_pct;
	int rcv_idle_pct;
	int req_seen [8];
	int status_seen [4];

	positional_list_engine_core #(
		.DEPTH(LIST_DEPTH)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_type   (req_type),
		.value      (value),
		.position   (position),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.status     (status),
		.entry_count(entry_count),
		.front_value(front_value),
		.back_value (back_value)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Applies one request to the software list and returns the result it causes.
	function automatic list_result_t apply_request(input logic [REQ_W-1:0] rt,
			input logic [DATA_W-1:0] v, input logic [POS_W-1:0] p);
		list_result_t r;
		int           idx;
		bit           do_ins;
		bit           do_del;
		int           k;
		r.st   = ST_DONE;
		idx    = 0;
		do_ins = 1'b0;
		do_del = 1'b0;
		case (rt)
			REQ_INS_FRONT: begin
				if (list_len >= LIST_DEPTH) r.st = ST_FULL;
				else begin do_ins = 1'b1; idx = 0; end
			end
			REQ_INS_POS: begin
				// The position is judged before fullness.
				if (p < 1 || p > list_len + 1) r.st = ST_BADPOS;
				else if (list_len >= LIST_DEPTH) r.st = ST_FULL;
				else begin do_ins = 1'b1; idx = p - 1; end
			end
			REQ_INS_BACK: begin
				if (list_len >= LIST_DEPTH) r.st = ST_FULL;
				else begin do_ins = 1'b1; idx = list_len; end
			end
			REQ_DEL_FRONT: begin
				if (list_len == 0) r.st = ST_EMPTY;
				else begin do_del = 1'b1; idx = 0; end
			end
			REQ_DEL_POS: begin
				// An empty list wins over a bad position.
				if (list_len == 0) r.st = ST_EMPTY;
				else if (p < 1 || p > list_len) r.st = ST_BADPOS;
				else begin do_del = 1'b1; idx = p - 1; end
			end
			REQ_DEL_BACK: begin
				if (list_len == 0) r.st = ST_EMPTY;
				else begin do_del = 1'b1; idx = list_len - 1; end
			end
			default: r.st = ST_DONE;
		endcase
		if (do_ins) begin
			for (k = list_len; k > idx; k--) list_mem[k] = list_mem[k-1];
			list_mem[idx] = v;
			list_len++;
		end
		if (do_del) begin
			for (k = idx; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
			list_len--;
		end
		r.cnt = list_len[CNT_OUT_W-1:0];
		if (list_len == 0) begin
			r.front = '0;
			r.back  = '0;
		end else begin
			r.front = list_mem[0];
			r.back  = list_mem[list_len-1];
		end
		return r;
	endfunction

	function automatic stim_row_t mk_row(input logic [REQ_W-1:0] rt,
			input logic [DATA_W-1:0] v, input logic [POS_W-1:0] p, input int reps,
			input bit typed, input logic [STAT_W-1:0] st, input logic [CNT_OUT_W-1:0] cnt,
			input logic [DATA_W-1:0] fr, input logic [DATA_W-1:0] bk);
		stim_row_t row;
		row.rt    = rt;
		row.val   = v;
		row.pos   = p;
		row.reps  = reps;
		row.typed = typed;
		row.want  = '{st: st, cnt: cnt, front: fr, back: bk};
		return row;
	endfunction

	// Drives one request transaction and records its expected result once taken.
	task automatic send_request(input logic [REQ_W-1:0] rt, input logic [DATA_W-1:0] v,
			input logic [POS_W-1:0] p, input bit typed, input list_result_t want);
		list_result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_type  <= rt;
		value     <= v;
		position  <= p;
		do @(posedge clk); while (!req_ready);
		predicted = apply_request(rt, v, p);
		expected_results.push_back(typed ? want : predicted);
		req_seen[rt]++;
		sent_count++;
	endtask

	// Holds the request side off until every outstanding result has come back.
	task automatic drain_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic run_random(input int n_items);
		int                done_items;
		int                mode;
		int                mode_left;
		int                roll;
		int                ins_pct;
		bit                is_ins;
		int                kind;
		logic [REQ_W-1:0]  rt;
		logic [DATA_W-1:0] v;
		logic [POS_W-1:0]  p;
		done_items = 0;
		mode       = 0;
		mode_left  = 0;
		while (done_items < n_items) begin
			// Alternate between filling, draining and churning the list.
			if (mode_left == 0) begin
				mode      = $urandom_range(2);
				mode_left = $urandom_range(40, 10);
			end
			mode_left--;
			roll = $urandom_range(99);
			p    = POS_W'($urandom_range(31));
			case ($urandom_range(7))
				0: v = VAL_MIN;
				1: v = VAL_MAX;
				2: v = VAL_NEG1;
				3: v = '0;
				default: v = $urandom;
			endcase
			if (roll < 3) begin
				rt = $urandom_range(1) ? REQ_NOP_A : REQ_NOP_B;
			end else begin
				if (roll < 13) begin
					rt = REQ_W'($urandom_range(5));
				end else begin
					ins_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
					is_ins  = ($urandom_range(99) < ins_pct);
					kind    = $urandom_range(2);
					case (kind)
						0: rt = is_ins ? REQ_INS_FRONT : REQ_DEL_FRONT;
						1: rt = is_ins ? REQ_INS_POS : REQ_DEL_POS;
						default: rt = is_ins ? REQ_INS_BACK : REQ_DEL_BACK;
					endcase
					if (kind == 1) begin
						if (is_ins) p = POS_W'($urandom_range(list_len + 1, 1));
						else p = (list_len == 0) ? POS_W'(1) :
							POS_W'($urandom_range(list_len, 1));
					end
				end
				done_items++;
			end
			send_request(rt, v, p, 1'b0, '0);
		end
	endtask

	// Response side: random back-pressure and the result check.
	always @(posedge clk) begin : rsp_check
		list_result_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				checked_count++;
				status_seen[status]++;
				if (expected_results.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("ERROR: result with no request pending: st=%0d cnt=%0d",
							status, entry_count);
				end else begin
					want = expected_results.pop_front();
					if (status !== want.st || entry_count !== want.cnt ||
							front_value !== want.front || back_value !== want.back) begin
						error_count++;
						if (error_count <= MAX_REPORTS) begin
							$display("ERROR: result %0d: expected st=%0d cnt=%0d front=%h back=%h",
								checked_count, want.st, want.cnt, want.front, want.back);
							$display("       got st=%0d cnt=%0d front=%h back=%h",
								status, entry_count, front_value, back_value);
						end
					end
				end
			end
			rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// Watchdog on cycles with no transaction on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
			else stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin : main
		int        i;
		int        r;
		stim_row_t row;
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req_type      = '0;
		value         = '0;
		position      = '0;
		list_len      = 0;
		sent_count    = 0;
		send_idle_pct = 10;
		rcv_idle_pct  = 50;
		foreach (req_seen[k]) req_seen[k] = 0;
		foreach (list_mem[k]) list_mem[k] = '0;

		// Deletes on the empty list after reset, bad positions, undefined codes.
		stim_rows.push_back(mk_row(REQ_DEL_FRONT, 0, 0, 1, 1, ST_EMPTY, 0, 0, 0));
		stim_rows.push_back(mk_row(REQ_DEL_POS, 0, 0, 1, 1, ST_EMPTY, 0, 0, 0));
		stim_rows.push_back(mk_row(REQ_DEL_POS, 0, 31, 1, 1, ST_EMPTY, 0, 0, 0));
		stim_rows.push_back(mk_row(REQ_DEL_BACK, 0, 0, 1, 1, ST_EMPTY, 0, 0, 0));
		stim_rows.push_back(mk_row(REQ_INS_POS, 5, 0, 1, 1, ST_BADPOS, 0, 0, 0));
		stim_rows.push_back(mk_row(REQ_INS_POS, 5, 2, 1, 1, ST_BADPOS, 0, 0, 0));
		stim_rows.push_back(mk_row(REQ_NOP_A, VAL_NEG1, 31, 1, 1, ST_DONE, 0, 0, 0));
		// Extreme values at both ends.
		stim_rows.push_back(mk_row(REQ_INS_POS, VAL_MIN, 1, 1, 1, ST_DONE, 1,
			VAL_MIN, VAL_MIN));
		stim_rows.push_back(mk_row(REQ_INS_BACK, VAL_MAX, 0, 1, 1, ST_DONE, 2,
			VAL_MIN, VAL_MAX));
		stim_rows.push_back(mk_row(REQ_NOP_B, 7, 4, 1, 1, ST_DONE, 2, VAL_MIN, VAL_MAX));
		stim_rows.push_back(mk_row(REQ_DEL_POS, 0, 0, 1, 1, ST_BADPOS, 2, VAL_MIN, VAL_MAX));
		stim_rows.push_back(mk_row(REQ_DEL_POS, 0, 3, 1, 1, ST_BADPOS, 2, VAL_MIN, VAL_MAX));
		stim_rows.push_back(mk_row(REQ_INS_POS, VAL_NEG1, 3, 1, 1, ST_DONE, 3,
			VAL_MIN, VAL_NEG1));
		stim_rows.push_back(mk_row(REQ_INS_FRONT, 0, 0, 1, 1, ST_DONE, 4, 0, VAL_NEG1));
		// Fill the store, then hit it with inserts while full.
		stim_rows.push_back(mk_row(REQ_INS_POS, 32'h1234_5678, 2, 1, 0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(REQ_INS_BACK, 32'hA5A5_A5A0, 0, 11, 0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(REQ_INS_FRONT, 32'h0BAD_F00D, 0, 1, 0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(REQ_INS_BACK, 32'h0BAD_F00D, 0, 1, 0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(REQ_INS_POS, 32'h0BAD_F00D, 17, 1, 0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(REQ_INS_POS, 32'h0BAD_F00D, 16, 1, 0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(REQ_INS_POS, 32'h0BAD_F00D, 31, 1, 0, 0, 0, 0, 0));
		// Positional deletes: out of range, last, first and a middle entry.
		stim_rows.push_back(mk_row(REQ_DEL_POS, 0, 17, 1, 0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(REQ_DEL_POS, 0, 16, 1, 0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(REQ_DEL_POS, 0, 1, 1, 0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(REQ_DEL_POS, 0, 7, 1, 0, 0, 0, 0, 0));
		// Drain to empty.
		stim_rows.push_back(mk_row(REQ_DEL_BACK, 0, 0, 12, 0, 0, 0, 0, 0));
		stim_rows.push_back(mk_row(REQ_DEL_FRONT, 0, 0, 1, 1, ST_DONE, 0, 0, 0));
		stim_rows.push_back(mk_row(REQ_DEL_BACK, 0, 0, 1, 1, ST_EMPTY, 0, 0, 0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Phase one: light gaps on the request side, heavy back-pressure.
		for (i = 0; i < stim_rows.size(); i++) begin
			row = stim_rows[i];
			for (r = 0; r < row.reps; r++)
				send_request(row.rt, row.val + r, row.pos, row.typed, row.want);
		end
		drain_results();
		run_random(270);
		drain_results();

		// Phase two: heavy gaps on the request side, light back-pressure.
		send_idle_pct = 50;
		rcv_idle_pct  = 10;
		run_random(270);
		drain_results();

		// Phase three: both sides at full rate.
		send_idle_pct = 0;
		rcv_idle_pct  = 0;
		run_random(260);

		req_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d requests (ins f/p/b %0d/%0d/%0d, del f/p/b %0d/%0d/%0d, nop %0d)",
			sent_count, req_seen[REQ_INS_FRONT], req_seen[REQ_INS_POS], req_seen[REQ_INS_BACK],
			req_seen[REQ_DEL_FRONT], req_seen[REQ_DEL_POS], req_seen[REQ_DEL_BACK],
			req_seen[REQ_NOP_A] + req_seen[REQ_NOP_B]);
		$display("Checked %0d results: done %0d, empty %0d, bad position %0d, full %0d",
			checked_count, status_seen[ST_DONE], status_seen[ST_EMPTY],
			status_seen[ST_BADPOS], status_seen[ST_FULL]);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
